// File: rtl/tcww_pkg.sv
`default_nettype none

package tcww_pkg;

   // screen size defaults
   localparam int DEF_COLS = 80;
   localparam int DEF_ROWS = 25;

   // field widths
   localparam int CMD_W      = 2;
   localparam int CHAR_W     = 8;
   localparam int ROW_W      = 5;
   localparam int COL_W      = 7;
   localparam int COLOUR_W   = 4;
   localparam int POS_W      = 11;
   localparam int DATA_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   // screen coordinates: window origin plus cursor or walker offset
   localparam int SCR_W = 8;
   // linear cell index before it is cut down to a store address
   localparam int LIN_W = 16;

   // command queue between front and back
   localparam int QDEPTH = 2;

   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

   localparam logic [CHAR_W-1:0] LF_CODE = 8'd10;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEFT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_TOP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FORE_COLOUR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BACK_COLOUR   = 3'd5;

   localparam logic [COL_W-1:0]    RST_WINDOW_WIDTH  = 7'd80;
   localparam logic [ROW_W-1:0]    RST_WINDOW_HEIGHT = 5'd25;
   localparam logic [COLOUR_W-1:0] RST_FORE_COLOUR   = 4'd15;
   localparam logic [COLOUR_W-1:0] RST_BACK_COLOUR   = 4'd0;

   typedef enum logic [2:0] {
      OP_PUT,
      OP_NEWLINE,
      OP_CLEAR,
      OP_READ,
      OP_NOP
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCR_RD,
      ST_SCR_WR,
      ST_FILL,
      ST_RESP
   } back_state_type;

   typedef struct packed {
      op_type            op;
      logic [CHAR_W-1:0] char_code;
      logic [ROW_W-1:0]  read_row;
      logic [COL_W-1:0]  read_col;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_head_type;

   typedef struct packed {
      logic pop;
      logic hold;
   } back_ctl_type;

   typedef struct packed {
      logic [COL_W-1:0]    left;
      logic [ROW_W-1:0]    top;
      logic [COL_W-1:0]    width;
      logic [ROW_W-1:0]    height;
      logic [COLOUR_W-1:0] fore;
      logic [COLOUR_W-1:0] back;
   } cfg_type;

endpackage

`default_nettype wire

// File: rtl/tcww_ram.sv
`default_nettype none

module tcww_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 2000,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: rtl/tcww_front.sv
`default_nettype none

module tcww_front
   import tcww_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output      logic              busy,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [CHAR_W-1:0] req_char_code,
   input  wire logic [ROW_W-1:0]  req_read_row,
   input  wire logic [COL_W-1:0]  req_read_col,
   input  wire back_ctl_type      ctl,
   output      q_head_type        head
);

   localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CNT_W = $clog2(QDEPTH + 1);

   item_type         q_ff [QDEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   item_type         new_item;
   logic             push;
   logic             pop;
   logic             full;

   assign full = (count_ff == CNT_W'(QDEPTH));
   assign busy = full | ctl.hold;
   assign push = start & ~busy;
   assign pop  = ctl.pop & (count_ff != '0);

   // decode the command on the way in so the back end only dispatches
   always_comb begin
      new_item.char_code = req_char_code;
      new_item.read_row  = req_read_row;
      new_item.read_col  = req_read_col;
      unique case (req_cmd)
         CMD_PUT: begin
            new_item.op = (req_char_code == LF_CODE) ? OP_NEWLINE : OP_PUT;
         end
         CMD_CLEAR: new_item.op = OP_CLEAR;
         CMD_READ:  new_item.op = OP_READ;
         CMD_NOP:   new_item.op = OP_NOP;
         default:   new_item.op = OP_NOP;
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = q_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// File: rtl/tcww_back.sv
`default_nettype none

module tcww_back
   import tcww_pkg::*;
#(
   parameter int COLS = DEF_COLS,
   parameter int ROWS = DEF_ROWS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire q_head_type        head,
   output      back_ctl_type      ctl,
   output      logic              rsp_strobe,
   output      logic [POS_W-1:0]  rsp_cursor_pos,
   output      logic [COL_W-1:0]  rsp_cursor_col,
   output      logic [ROW_W-1:0]  rsp_cursor_row,
   output      logic [DATA_W-1:0] rsp_cell_data
);

   localparam int CELLS  = COLS * ROWS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   back_state_type    state_ff, state_in;
   logic [COL_W-1:0]  cur_col_ff, cur_col_in;
   logic [ROW_W-1:0]  cur_row_ff, cur_row_in;
   logic [COL_W-1:0]  cnt_col_ff, cnt_col_in;
   logic [ROW_W-1:0]  cnt_row_ff, cnt_row_in;
   logic [ADDR_W-1:0] init_addr_ff, init_addr_in;
   logic              src_ok_ff, src_ok_in;
   logic              read_hit_ff, read_hit_in;

   logic              rsp_strobe_ff, rsp_strobe_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, rd_data;

   logic [COL_W-1:0]  w_eff, w_last;
   logic [ROW_W-1:0]  h_eff, h_last;
   logic [7:0]        attr;
   logic [SCR_W-1:0]  cur_srow, cur_scol;
   logic [SCR_W-1:0]  walk_srow, walk_scol, dest_srow;
   logic [SCR_W-1:0]  read_srow, read_scol;
   logic [LIN_W-1:0]  lin_cur, lin_walk, lin_dest, lin_read;
   logic [COL_W:0]    col_step, col_wrap;
   logic [ROW_W:0]    row_step, row_wrap;
   logic              scroll_need;
   logic              col_last, row_last;

   function automatic logic on_scr(input logic [SCR_W-1:0] r, input logic [SCR_W-1:0] c);
      return (r < SCR_W'(ROWS)) && (c < SCR_W'(COLS));
   endfunction

   function automatic logic [LIN_W-1:0] lin_of(input logic [SCR_W-1:0] r,
                                               input logic [SCR_W-1:0] c);
      return LIN_W'(r) * LIN_W'(COLS) + LIN_W'(c);
   endfunction

   tcww_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CELLS),
      .ADDR_W(ADDR_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // zero width or height behaves as one
   assign w_eff  = (cfg.width == '0) ? COL_W'(1) : cfg.width;
   assign h_eff  = (cfg.height == '0) ? ROW_W'(1) : cfg.height;
   assign w_last = w_eff - 1'b1;
   assign h_last = h_eff - 1'b1;
   assign attr   = {cfg.back, cfg.fore};

   assign cur_srow  = SCR_W'(cfg.top) + SCR_W'(cur_row_ff);
   assign cur_scol  = SCR_W'(cfg.left) + SCR_W'(cur_col_ff);
   assign walk_srow = SCR_W'(cfg.top) + SCR_W'(cnt_row_ff);
   assign walk_scol = SCR_W'(cfg.left) + SCR_W'(cnt_col_ff);
   assign dest_srow = walk_srow - 1'b1;
   assign read_srow = SCR_W'(head.item.read_row);
   assign read_scol = SCR_W'(head.item.read_col);

   assign lin_cur  = lin_of(cur_srow, cur_scol);
   assign lin_walk = lin_of(walk_srow, walk_scol);
   assign lin_dest = lin_of(dest_srow, walk_scol);
   assign lin_read = lin_of(read_srow, read_scol);

   assign col_last = (cnt_col_ff == w_last);
   assign row_last = (cnt_row_ff == h_last);

   // cursor advance for a put or a line feed
   always_comb begin
      if (head.item.op == OP_NEWLINE) begin
         col_step = '0;
         row_step = {1'b0, cur_row_ff} + 1'b1;
      end else begin
         col_step = {1'b0, cur_col_ff} + 1'b1;
         row_step = {1'b0, cur_row_ff};
      end
      if (col_step >= {1'b0, w_eff}) begin
         col_wrap = '0;
         row_wrap = row_step + 1'b1;
      end else begin
         col_wrap = col_step;
         row_wrap = row_step;
      end
      scroll_need = (row_wrap >= {1'b0, h_eff});
   end

   always_comb begin
      state_in      = state_ff;
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      cnt_col_in    = cnt_col_ff;
      cnt_row_in    = cnt_row_ff;
      init_addr_in  = init_addr_ff;
      src_ok_in     = src_ok_ff;
      read_hit_in   = read_hit_ff;
      rsp_strobe_in = 1'b0;
      rsp_pos_in    = rsp_pos_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = lin_walk[ADDR_W-1:0];
      wr_data       = {attr, 8'h00};
      rd_en         = 1'b0;
      rd_addr       = lin_walk[ADDR_W-1:0];
      ctl.pop       = 1'b0;
      ctl.hold      = (state_ff == ST_INIT);

      unique case (state_ff)
         ST_INIT: begin
            wr_en   = 1'b1;
            wr_addr = init_addr_ff;
            wr_data = '0;
            if (init_addr_ff == ADDR_W'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               init_addr_in = init_addr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (head.valid) begin
               ctl.pop     = 1'b1;
               read_hit_in = 1'b0;
               cnt_col_in  = '0;
               state_in    = ST_RESP;
               unique case (head.item.op)
                  OP_PUT, OP_NEWLINE: begin
                     if (head.item.op == OP_PUT) begin
                        wr_en   = on_scr(cur_srow, cur_scol);
                        wr_addr = lin_cur[ADDR_W-1:0];
                        wr_data = {attr, head.item.char_code};
                     end
                     if (scroll_need) begin
                        cur_col_in = '0;
                        cur_row_in = h_last;
                        if (h_eff == ROW_W'(1)) begin
                           cnt_row_in = '0;
                           state_in   = ST_FILL;
                        end else begin
                           cnt_row_in = ROW_W'(1);
                           state_in   = ST_SCR_RD;
                        end
                     end else begin
                        cur_col_in = col_wrap[COL_W-1:0];
                        cur_row_in = row_wrap[ROW_W-1:0];
                     end
                  end
                  OP_CLEAR: begin
                     cur_col_in = '0;
                     cur_row_in = '0;
                     cnt_row_in = '0;
                     state_in   = ST_FILL;
                  end
                  OP_READ: begin
                     rd_en       = 1'b1;
                     rd_addr     = lin_read[ADDR_W-1:0];
                     read_hit_in = on_scr(read_srow, read_scol);
                  end
                  OP_NOP: begin
                  end
                  default: begin
                  end
               endcase
            end
         end

         // scroll copies one cell per read/write pair, row r to row r-1
         ST_SCR_RD: begin
            rd_en     = 1'b1;
            src_ok_in = on_scr(walk_srow, walk_scol);
            state_in  = ST_SCR_WR;
         end

         ST_SCR_WR: begin
            wr_en   = on_scr(dest_srow, walk_scol);
            wr_addr = lin_dest[ADDR_W-1:0];
            wr_data = src_ok_ff ? rd_data : '0;
            if (col_last) begin
               cnt_col_in = '0;
               if (row_last) begin
                  state_in = ST_FILL;
               end else begin
                  cnt_row_in = cnt_row_ff + 1'b1;
                  state_in   = ST_SCR_RD;
               end
            end else begin
               cnt_col_in = cnt_col_ff + 1'b1;
               state_in   = ST_SCR_RD;
            end
         end

         // blanks from cnt_row to the bottom window row
         ST_FILL: begin
            wr_en = on_scr(walk_srow, walk_scol);
            if (col_last) begin
               cnt_col_in = '0;
               if (row_last) begin
                  state_in = ST_RESP;
               end else begin
                  cnt_row_in = cnt_row_ff + 1'b1;
               end
            end else begin
               cnt_col_in = cnt_col_ff + 1'b1;
            end
         end

         ST_RESP: begin
            rsp_strobe_in = 1'b1;
            rsp_pos_in    = lin_cur[POS_W-1:0];
            rsp_col_in    = cur_col_ff;
            rsp_row_in    = cur_row_ff;
            rsp_data_in   = read_hit_ff ? rd_data : '0;
            state_in      = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         init_addr_ff  <= '0;
         read_hit_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         init_addr_ff  <= init_addr_in;
         read_hit_ff   <= read_hit_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_col_ff  <= cnt_col_in;
      cnt_row_ff  <= cnt_row_in;
      src_ok_ff   <= src_ok_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_cursor_pos = rsp_pos_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cell_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: rtl/text_console_window_writer_unit.sv
// Text console writing into a COLS x ROWS store of 16-bit cells (character in the
// low byte, attribute in the high byte) inside a configurable window. Commands are
// taken while busy is low and wait in a two-deep queue; a single sequencer owns the
// cell store (one write and one registered read port) and carries them out. After
// reset the sequencer zeroes the store one cell a cycle, with busy held high; register
// writes are taken throughout. Put, line feed without scroll, read and no-op go straight
// from dispatch to the result. Clear blanks the whole window; a put or line feed that
// scrolls moves the window contents up one row and blanks its bottom row; the
// scroll copies each cell of the window through the store's read port, one
// read and one write per cell. Each command gives exactly one result, shown for one
// cycle with rsp_strobe, which the receiver must take as it comes. Window registers
// are to be written only while no command is outstanding.

`default_nettype none

module text_console_window_writer_unit
   import tcww_pkg::*;
#(
   parameter int COLS = DEF_COLS,
   parameter int ROWS = DEF_ROWS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire logic [CMD_W-1:0]      req_cmd,
   input  wire logic [CHAR_W-1:0]     req_char_code,
   input  wire logic [ROW_W-1:0]      req_read_row,
   input  wire logic [COL_W-1:0]      req_read_col,
   output      logic                  rsp_strobe,
   output      logic [POS_W-1:0]      rsp_cursor_pos,
   output      logic [COL_W-1:0]      rsp_cursor_col,
   output      logic [ROW_W-1:0]      rsp_cursor_row,
   output      logic [DATA_W-1:0]     rsp_cell_data,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg_ff, cfg_in;
   q_head_type   head;
   back_ctl_type ctl;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_WINDOW_LEFT:   cfg_in.left   = csr_wdata;
            CSR_WINDOW_TOP:    cfg_in.top    = csr_wdata[ROW_W-1:0];
            CSR_WINDOW_WIDTH:  cfg_in.width  = csr_wdata;
            CSR_WINDOW_HEIGHT: cfg_in.height = csr_wdata[ROW_W-1:0];
            CSR_FORE_COLOUR:   cfg_in.fore   = csr_wdata[COLOUR_W-1:0];
            CSR_BACK_COLOUR:   cfg_in.back   = csr_wdata[COLOUR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left   <= '0;
         cfg_ff.top    <= '0;
         cfg_ff.width  <= RST_WINDOW_WIDTH;
         cfg_ff.height <= RST_WINDOW_HEIGHT;
         cfg_ff.fore   <= RST_FORE_COLOUR;
         cfg_ff.back   <= RST_BACK_COLOUR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tcww_front u_front (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_char_code(req_char_code),
      .req_read_row (req_read_row),
      .req_read_col (req_read_col),
      .ctl          (ctl),
      .head         (head)
   );

   tcww_back #(
      .COLS(COLS),
      .ROWS(ROWS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .head          (head),
      .ctl           (ctl),
      .rsp_strobe    (rsp_strobe),
      .rsp_cursor_pos(rsp_cursor_pos),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row),
      .rsp_cell_data (rsp_cell_data)
   );

endmodule

`default_nettype wire
